// File: rtl/core/ipsc_pkg.sv
// ----------------------------------------------------------------------------
// ipsc_pkg
// Types and fixed constants of the incremental PID speed controller: field
// widths, register reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ipsc_pkg;

   // field widths
   localparam int POS_W    = 11;
   localparam int ERR_W    = 16;
   localparam int SCALE_W  = 10;
   localparam int GAIN_W   = 16;
   localparam int ILIM_W   = 15;
   localparam int DLIM_W   = 8;
   localparam int DIR_W    = 2;
   localparam int MAG_W    = 8;
   localparam int MEAS_W   = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W    = 16;

   // shift-and-add datapath
   localparam int ACC_W    = 56;                 // holds the full PID numerator
   localparam int MPL_W    = 16;                 // widest multiplier operand
   localparam int DERR_W   = ERR_W + 1 + SCALE_W;
   localparam int NUM_W    = ACC_W - 8;          // numerator after the Q8.8 shift
   localparam int CNT_W    = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

   // drive arithmetic
   localparam int Q_W      = 9;                  // increment magnitude, saturated
   localparam int PREV_W   = 9;
   localparam int DRV_W    = Q_W + 2;

   // saturation codes
   localparam logic [ERR_W-1:0]  ERR_POS  = 16'h7FFF;
   localparam logic [ERR_W-1:0]  ERR_NEG  = 16'h8000;
   localparam logic [MEAS_W-1:0] MEAS_POS = 18'h1FFFF;
   localparam logic [MEAS_W-1:0] MEAS_NEG = 18'h20000;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_FWD = 2'b10;
   localparam logic [DIR_W-1:0] DIR_REV = 2'b01;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_INTERVAL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT    = 3'd7;

   // register reset values
   localparam logic [15:0]        RST_RUN_INTERVAL   = 16'd250;
   localparam logic [SCALE_W-1:0] RST_SPEED_SCALE    = 10'd62;
   localparam logic [GAIN_W-1:0]  RST_GAIN_P         = 16'd41;
   localparam logic [GAIN_W-1:0]  RST_GAIN_I         = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_GAIN_D         = 16'd0;
   localparam logic [ILIM_W-1:0]  RST_INTEGRAL_LIMIT = 15'd24800;
   localparam logic [15:0]        RST_SPEED_LIMIT    = 16'd1500;
   localparam logic [DLIM_W-1:0]  RST_DRIVE_LIMIT    = 8'd200;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SPEED,
      ST_FIX,
      ST_ERR,
      ST_SUM,
      ST_DERR,
      ST_MP,
      ST_MD,
      ST_MS,
      ST_MI,
      ST_DIV,
      ST_DRIVE
   } state_type;

endpackage

// File: rtl/core/incremental_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// incremental_pid_speed_controller
// Timer-tick driven incremental PID speed loop with a bit-serial datapath.
// ----------------------------------------------------------------------------
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-------------
//   req     | in        | req_target_speed, req_position          | valid/ready
//   rsp     | out       | rsp_direction, rsp_magnitude,           | valid/ready
//           |           | rsp_measured_speed                      |
//   csr     | in        | csr_index, csr_data                     | valid/ready
//
// A tick that does not fire the prescaler gives no item. A firing tick runs the
// sequencer: each product goes through one shared shift-and-add unit at one
// multiplier bit a cycle, and the final division is a 48-step restoring
// divider, one quotient bit a cycle. Reset is synchronous and restores the
// register defaults. While a result waits in the rsp register, ticks are still
// taken; a further run holds in its last step, with req_ready low, until that
// register frees.
// ----------------------------------------------------------------------------
module incremental_pid_speed_controller
   import ipsc_pkg::*;
#(
   parameter int HISTORY_SPAN   = 2,
   parameter int ROTATION_TICKS = 1080
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [ERR_W-1:0]  req_target_speed,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DIR_W-1:0]         rsp_direction,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic signed [MEAS_W-1:0] rsp_measured_speed,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   localparam int ROT_W   = $clog2(ROTATION_TICKS + 1);
   localparam int WRAP_W  = ROT_W + SCALE_W;
   localparam int RAW_W   = POS_W + SCALE_W;
   localparam int SPEED_W = ((WRAP_W > RAW_W) ? WRAP_W : RAW_W) + 2;

   // configuration
   logic [15:0]        run_interval_ff;
   logic [SCALE_W-1:0] speed_scale_ff;
   logic [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [ILIM_W-1:0]  integral_limit_ff;
   logic [15:0]        speed_limit_ff;
   logic [DLIM_W-1:0]  drive_limit_ff;

   // control and loop state
   state_type          state_ff, state_in;
   logic [15:0]        countdown_ff, countdown_in;
   logic [POS_W-1:0]   hist_ff [HISTORY_SPAN+1];
   logic [POS_W-1:0]   hist_in [HISTORY_SPAN+1];
   logic [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic [ERR_W-1:0]   err_sum_ff, err_sum_in;
   logic [PREV_W-1:0]  prev_drive_ff, prev_drive_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [ERR_W-1:0]   target_ff, target_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [MPL_W-1:0]   mplier_ff, mplier_in;
   logic [WRAP_W-1:0]  wrap_ff, wrap_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [MEAS_W-1:0]  meas_ff, meas_in;
   logic [DERR_W-1:0]  derr_ff, derr_in;
   logic               sign_ff, sign_in;
   logic [SCALE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIR_W-1:0]   rsp_direction_ff, rsp_direction_in;
   logic [MAG_W-1:0]   rsp_magnitude_ff, rsp_magnitude_in;
   logic [MEAS_W-1:0]  rsp_meas_ff, rsp_meas_in;

   // combinational helpers
   logic               req_fire, rsp_fire, out_free, mul_done;
   logic [15:0]        tick_dec;
   logic [ACC_W-1:0]   acc_step, mcand_step, abs_acc;
   logic [MPL_W-1:0]   mplier_step;
   logic [SCALE_W-1:0] s_eff;
   logic [POS_W:0]     pos_diff;
   logic [ERR_W:0]     err_delta;
   logic [SPEED_W-1:0] fix_lim, fix_neg_lim, fix_wrap;
   logic [SPEED_W:0]   err_diff;
   logic               err_fits, meas_fits;
   logic [ERR_W:0]     sum_ext;
   logic [ERR_W-1:0]   sum_sat, int_lim, int_neg_lim;
   logic [SCALE_W:0]   trial;
   logic [SCALE_W+1:0] trial_diff;
   logic               trial_ge, q_big;
   logic [Q_W-1:0]     q_mag;
   logic [DRV_W-1:0]   inc, drive_sum, drive_lim, drive_neg_lim, drive_val, drive_neg;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tick_dec = countdown_ff - 16'd1;

   assign mul_done    = (mplier_ff == '0);
   assign acc_step    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign mcand_step  = {mcand_ff[ACC_W-2:0], 1'b0};
   assign mplier_step = {1'b0, mplier_ff[MPL_W-1:1]};
   assign s_eff       = (speed_scale_ff == '0) ? SCALE_W'(1) : speed_scale_ff;

   assign pos_diff  = {1'b0, hist_ff[HISTORY_SPAN]} - {1'b0, hist_ff[0]};
   assign err_delta = {err_ff[ERR_W-1], err_ff} - {prev_err_ff[ERR_W-1], prev_err_ff};

   // wrap correction bounds
   assign fix_lim     = SPEED_W'(speed_limit_ff);
   assign fix_neg_lim = ~fix_lim + SPEED_W'(1);
   assign fix_wrap    = SPEED_W'(wrap_ff);

   // error and shown speed, both saturated
   assign err_diff  = {{(SPEED_W+1-ERR_W){target_ff[ERR_W-1]}}, target_ff}
                      - {speed_ff[SPEED_W-1], speed_ff};
   assign err_fits  = (err_diff[SPEED_W:ERR_W-1] == '0) ||
                      (err_diff[SPEED_W:ERR_W-1] == '1);
   assign meas_fits = (speed_ff[SPEED_W-1:MEAS_W-1] == '0) ||
                      (speed_ff[SPEED_W-1:MEAS_W-1] == '1);

   // integral update
   assign sum_ext     = {err_sum_ff[ERR_W-1], err_sum_ff} + {err_ff[ERR_W-1], err_ff};
   assign sum_sat     = (sum_ext[ERR_W] == sum_ext[ERR_W-1]) ? sum_ext[ERR_W-1:0]
                        : (sum_ext[ERR_W] ? ERR_NEG : ERR_POS);
   assign int_lim     = {1'b0, integral_limit_ff};
   assign int_neg_lim = ~int_lim + ERR_W'(1);

   // numerator magnitude and one restoring-division step
   assign abs_acc    = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign trial      = {rem_ff, acc_ff[NUM_W-1]};
   assign trial_diff = {1'b0, trial} - {2'b00, s_eff};
   assign trial_ge   = !trial_diff[SCALE_W+1];

   // drive update
   assign q_big         = |acc_ff[NUM_W-1:Q_W];
   assign q_mag         = q_big ? '1 : acc_ff[Q_W-1:0];
   assign inc           = sign_ff ? (~{2'b00, q_mag} + DRV_W'(1)) : {2'b00, q_mag};
   assign drive_sum     = {{(DRV_W-PREV_W){prev_drive_ff[PREV_W-1]}}, prev_drive_ff} + inc;
   assign drive_lim     = DRV_W'(drive_limit_ff);
   assign drive_neg_lim = ~drive_lim + DRV_W'(1);
   always_comb begin
      if ($signed(drive_sum) > $signed(drive_lim)) begin
         drive_val = drive_lim;
      end else if ($signed(drive_sum) < $signed(drive_neg_lim)) begin
         drive_val = drive_neg_lim;
      end else begin
         drive_val = drive_sum;
      end
   end
   assign drive_neg = ~drive_val + DRV_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && tick_dec == '0) state_in = ST_WRAP;
         ST_WRAP:  if (mul_done) state_in = ST_SPEED;
         ST_SPEED: if (mul_done) state_in = ST_FIX;
         ST_FIX:   state_in = ST_ERR;
         ST_ERR:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_DERR;
         ST_DERR:  if (mul_done) state_in = ST_MP;
         ST_MP:    if (mul_done) state_in = ST_MD;
         ST_MD:    if (mul_done) state_in = ST_MS;
         ST_MS:    if (mul_done) state_in = ST_MI;
         ST_MI:    if (mul_done) state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == DIV_LAST) state_in = ST_DRIVE;
         ST_DRIVE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready          = (state_ff == ST_IDLE);
      csr_ready          = 1'b1;
      rsp_valid          = rsp_valid_ff;
      rsp_direction      = rsp_direction_ff;
      rsp_magnitude      = rsp_magnitude_ff;
      rsp_measured_speed = $signed(rsp_meas_ff);
   end

   // datapath next values
   always_comb begin
      countdown_in     = countdown_ff;
      hist_in          = hist_ff;
      prev_err_in      = prev_err_ff;
      err_sum_in       = err_sum_ff;
      prev_drive_in    = prev_drive_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_fire;
      target_in        = target_ff;
      acc_in           = acc_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      wrap_in          = wrap_ff;
      speed_in         = speed_ff;
      err_in           = err_ff;
      meas_in          = meas_ff;
      derr_in          = derr_ff;
      sign_in          = sign_ff;
      rem_in           = rem_ff;
      cnt_in           = cnt_ff;
      rsp_direction_in = rsp_direction_ff;
      rsp_magnitude_in = rsp_magnitude_ff;
      rsp_meas_in      = rsp_meas_ff;

      // every multiply state steps until the multiplier runs out of ones
      if (!mul_done) begin
         acc_in    = acc_step;
         mcand_in  = mcand_step;
         mplier_in = mplier_step;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               countdown_in = tick_dec;
               if (tick_dec == '0) begin
                  countdown_in = run_interval_ff;
                  target_in    = req_target_speed;
                  for (int k = 0; k < HISTORY_SPAN; k++) begin
                     hist_in[k] = hist_ff[k+1];
                  end
                  hist_in[HISTORY_SPAN] = req_position;
                  // wrap distance: one rotation times the scale
                  acc_in    = '0;
                  mcand_in  = ACC_W'(ROTATION_TICKS);
                  mplier_in = MPL_W'(speed_scale_ff);
               end
            end
         end
         ST_WRAP: begin
            if (mul_done) begin
               wrap_in   = acc_ff[WRAP_W-1:0];
               acc_in    = '0;
               mcand_in  = {{(ACC_W-POS_W-1){pos_diff[POS_W]}}, pos_diff};
               mplier_in = MPL_W'(speed_scale_ff);
            end
         end
         ST_SPEED: begin
            if (mul_done) begin
               speed_in = acc_ff[SPEED_W-1:0];
            end
         end
         ST_FIX: begin
            if ($signed(speed_ff) < $signed(fix_neg_lim)) begin
               speed_in = speed_ff + fix_wrap;
            end else if ($signed(speed_ff) > $signed(fix_lim)) begin
               speed_in = speed_ff - fix_wrap;
            end
         end
         ST_ERR: begin
            err_in  = err_fits ? err_diff[ERR_W-1:0]
                      : (err_diff[SPEED_W] ? ERR_NEG : ERR_POS);
            meas_in = meas_fits ? speed_ff[MEAS_W-1:0]
                      : (speed_ff[SPEED_W-1] ? MEAS_NEG : MEAS_POS);
         end
         ST_SUM: begin
            if ($signed(sum_sat) > $signed(int_lim)) begin
               err_sum_in = int_lim;
            end else if ($signed(sum_sat) < $signed(int_neg_lim)) begin
               err_sum_in = int_neg_lim;
            end else begin
               err_sum_in = sum_sat;
            end
            prev_err_in = err_ff;
            acc_in      = '0;
            mcand_in    = {{(ACC_W-ERR_W-1){err_delta[ERR_W]}}, err_delta};
            mplier_in   = MPL_W'(speed_scale_ff);
         end
         ST_DERR: begin
            if (mul_done) begin
               derr_in   = acc_ff[DERR_W-1:0];
               acc_in    = '0;
               mcand_in  = {{(ACC_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
               mplier_in = gain_p_ff;
            end
         end
         ST_MP: begin
            // accumulate derivative term on top of the proportional term
            if (mul_done) begin
               mcand_in  = {{(ACC_W-DERR_W){derr_ff[DERR_W-1]}}, derr_ff};
               mplier_in = gain_d_ff;
            end
         end
         ST_MD: begin
            if (mul_done) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = MPL_W'(s_eff);
            end
         end
         ST_MS: begin
            if (mul_done) begin
               mcand_in  = {{(ACC_W-ERR_W){err_sum_ff[ERR_W-1]}}, err_sum_ff};
               mplier_in = gain_i_ff;
            end
         end
         ST_MI: begin
            // drop the Q8.8 fraction on the magnitude, keep the sign apart
            if (mul_done) begin
               sign_in = acc_ff[ACC_W-1];
               acc_in  = {8'd0, abs_acc[ACC_W-1:8]};
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         ST_DIV: begin
            rem_in             = trial_ge ? trial_diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
            acc_in             = '0;
            acc_in[NUM_W-1:0]  = {acc_ff[NUM_W-2:0], trial_ge};
            cnt_in             = cnt_ff + CNT_W'(1);
         end
         ST_DRIVE: begin
            if (out_free) begin
               prev_drive_in = drive_val[PREV_W-1:0];
               rsp_valid_in  = 1'b1;
               rsp_meas_in   = meas_ff;
               if ($signed(drive_val) > $signed(DRV_W'(0))) begin
                  rsp_direction_in = DIR_FWD;
                  rsp_magnitude_in = drive_val[MAG_W-1:0];
               end else begin
                  rsp_direction_in = DIR_REV;
                  rsp_magnitude_in = drive_neg[MAG_W-1:0];
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_fire;
         end
      endcase
   end

   // control, configuration and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         countdown_ff      <= RST_RUN_INTERVAL;
         for (int k = 0; k <= HISTORY_SPAN; k++) begin
            hist_ff[k] <= '0;
         end
         prev_err_ff       <= '0;
         err_sum_ff        <= '0;
         prev_drive_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
         run_interval_ff   <= RST_RUN_INTERVAL;
         speed_scale_ff    <= RST_SPEED_SCALE;
         gain_p_ff         <= RST_GAIN_P;
         gain_i_ff         <= RST_GAIN_I;
         gain_d_ff         <= RST_GAIN_D;
         integral_limit_ff <= RST_INTEGRAL_LIMIT;
         speed_limit_ff    <= RST_SPEED_LIMIT;
         drive_limit_ff    <= RST_DRIVE_LIMIT;
      end else begin
         state_ff      <= state_in;
         countdown_ff  <= countdown_in;
         hist_ff       <= hist_in;
         prev_err_ff   <= prev_err_in;
         err_sum_ff    <= err_sum_in;
         prev_drive_ff <= prev_drive_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RUN_INTERVAL:   run_interval_ff   <= csr_data;
               CSR_SPEED_SCALE:    speed_scale_ff    <= csr_data[SCALE_W-1:0];
               CSR_GAIN_P:         gain_p_ff         <= csr_data;
               CSR_GAIN_I:         gain_i_ff         <= csr_data;
               CSR_GAIN_D:         gain_d_ff         <= csr_data;
               CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data[ILIM_W-1:0];
               CSR_SPEED_LIMIT:    speed_limit_ff    <= csr_data;
               CSR_DRIVE_LIMIT:    drive_limit_ff    <= csr_data[DLIM_W-1:0];
               default:            drive_limit_ff    <= drive_limit_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      target_ff        <= target_in;
      acc_ff           <= acc_in;
      mcand_ff         <= mcand_in;
      mplier_ff        <= mplier_in;
      wrap_ff          <= wrap_in;
      speed_ff         <= speed_in;
      err_ff           <= err_in;
      meas_ff          <= meas_in;
      derr_ff          <= derr_in;
      sign_ff          <= sign_in;
      rem_ff           <= rem_in;
      cnt_ff           <= cnt_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_magnitude_ff <= rsp_magnitude_in;
      rsp_meas_ff      <= rsp_meas_in;
   end

endmodule

// File: tb/tb_incremental_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// tb_incremental_pid_speed_controller
// Self-checking bench for the tick-driven incremental PID speed loop. A local
// model of the controller predicts direction, magnitude and measured speed
// for every firing tick; each rsp item is compared in order of arrival.
// A run at the reset defaults comes first, then directed extremes, then
// register sets with encoder-like random walks under changing handshake
// idling, a longer prescaler interval and a long rsp stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_incremental_pid_speed_controller;
   import ipsc_pkg::*;

   localparam int HISTORY_SPAN   = 2;
   localparam int ROTATION_TICKS = 1080;
   localparam int SETTLE_CYCLES  = 200;   // longest update plus margin
   localparam int HOLD_CYCLES    = 600;
   localparam int RANDOM_TICKS   = 150;

   typedef struct {
      logic [DIR_W-1:0]         direction;
      logic [MAG_W-1:0]         magnitude;
      logic signed [MEAS_W-1:0] measured_speed;
   } speed_update_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ERR_W-1:0]  req_target_speed = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DIR_W-1:0]         rsp_direction;
   logic [MAG_W-1:0]         rsp_magnitude;
   logic signed [MEAS_W-1:0] rsp_measured_speed;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]         csr_data = '0;

   // controller model: registers and state
   int          cfg_run_interval   = 250;
   int          cfg_speed_scale    = 62;
   int          cfg_gain_p         = 41;
   int          cfg_gain_i         = 0;
   int          cfg_gain_d         = 0;
   int          cfg_integral_limit = 24800;
   int          cfg_speed_limit    = 1500;
   int          cfg_drive_limit    = 200;
   logic [15:0] countdown = 16'd250;
   int          position_hist[HISTORY_SPAN+1] = '{default: 0};
   longint      held_error = 0;
   longint      error_sum  = 0;
   longint      last_drive = 0;

   speed_update_type expected_updates[$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_requests   = 0;
   int hold_served     = 0;
   int hold_left       = 0;
   int enc_pos         = 0;
   int ticks_sent      = 0;
   int updates_checked = 0;
   int reg_writes      = 0;
   int mismatch_count  = 0;

   incremental_pid_speed_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_speed   (req_target_speed),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_direction      (rsp_direction),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_measured_speed (rsp_measured_speed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the prescaler; on a firing tick run one PID update
   task automatic predict_update(input logic signed [ERR_W-1:0] tgt,
                                 input logic [POS_W-1:0] pos);
      longint spd, err, derr, s_eff, num, inc, drv;
      speed_update_type upd;
      countdown = countdown - 16'd1;
      if (countdown != 16'd0) return;
      countdown = 16'(cfg_run_interval);
      for (int k = 0; k < HISTORY_SPAN; k++) position_hist[k] = position_hist[k+1];
      position_hist[HISTORY_SPAN] = int'(pos);
      spd = longint'(position_hist[HISTORY_SPAN] - position_hist[0]) * cfg_speed_scale;
      // treat a span beyond the limit as a wrap through position zero
      if (spd < -longint'(cfg_speed_limit))
         spd += longint'(ROTATION_TICKS) * cfg_speed_scale;
      else if (spd > longint'(cfg_speed_limit))
         spd -= longint'(ROTATION_TICKS) * cfg_speed_scale;
      err = clip(longint'(tgt) - spd, -32768, 32767);
      derr = (err - held_error) * cfg_speed_scale;
      error_sum = clip(clip(error_sum + err, -32768, 32767),
                       -longint'(cfg_integral_limit), longint'(cfg_integral_limit));
      s_eff = (cfg_speed_scale != 0) ? longint'(cfg_speed_scale) : 64'sd1;
      num = (err * cfg_gain_p + derr * cfg_gain_d) * s_eff + error_sum * cfg_gain_i;
      inc = num / (256 * s_eff);
      drv = clip(last_drive + inc, -longint'(cfg_drive_limit), longint'(cfg_drive_limit));
      last_drive = drv;
      held_error = err;
      if (drv > 0) begin
         upd.direction = DIR_FWD;
         upd.magnitude = 8'(drv);
      end else begin
         upd.direction = DIR_REV;
         upd.magnitude = 8'(-drv);
      end
      upd.measured_speed = 18'(clip(spd, -131072, 131071));
      expected_updates.push_back(upd);
   endtask

   function automatic int ticks_to_fire();
      return (countdown == 16'd0) ? 65536 : int'(countdown);
   endfunction

   task automatic send_tick(input logic signed [ERR_W-1:0] tgt,
                            input logic [POS_W-1:0] pos);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_target_speed <= tgt;
      req_position     <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
      predict_update(tgt, pos);
   endtask

   // encoder-like walk most of the time, arbitrary values now and then
   task automatic send_random_ticks(input int count);
      logic signed [ERR_W-1:0] tgt;
      logic [POS_W-1:0]        pos;
      for (int k = 0; k < count; k++) begin
         enc_pos = (enc_pos + ROTATION_TICKS + $urandom_range(120) - 60) % ROTATION_TICKS;
         pos = ($urandom_range(9) == 0) ? POS_W'($urandom) : POS_W'(enc_pos);
         tgt = ($urandom_range(4) == 0) ? ERR_W'($urandom)
                                        : ERR_W'(int'($urandom_range(6000)) - 3000);
         send_tick(tgt, pos);
      end
   endtask

   // drop valid, wait for every pending update, then let the sequencer settle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_writes++;
      case (idx)
         CSR_RUN_INTERVAL:   cfg_run_interval   = int'(data);
         CSR_SPEED_SCALE:    cfg_speed_scale    = int'(data[SCALE_W-1:0]);
         CSR_GAIN_P:         cfg_gain_p         = int'(data);
         CSR_GAIN_I:         cfg_gain_i         = int'(data);
         CSR_GAIN_D:         cfg_gain_d         = int'(data);
         CSR_INTEGRAL_LIMIT: cfg_integral_limit = int'(data[ILIM_W-1:0]);
         CSR_SPEED_LIMIT:    cfg_speed_limit    = int'(data);
         CSR_DRIVE_LIMIT:    cfg_drive_limit    = int'(data[DLIM_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic program_regs(input int ri, input int ss, input int gp, input int gi,
                               input int gd, input int il, input int sl, input int dl);
      quiesce();
      write_reg(CSR_RUN_INTERVAL,   16'(ri));
      write_reg(CSR_SPEED_SCALE,    16'(ss));
      write_reg(CSR_GAIN_P,         16'(gp));
      write_reg(CSR_GAIN_I,         16'(gi));
      write_reg(CSR_GAIN_D,         16'(gd));
      write_reg(CSR_INTEGRAL_LIMIT, 16'(il));
      write_reg(CSR_SPEED_LIMIT,    16'(sl));
      write_reg(CSR_DRIVE_LIMIT,    16'(dl));
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_gain();
      case ($urandom_range(4))
         0:       return 0;
         1:       return int'($urandom_range(65535));
         default: return int'($urandom_range(1024));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_random_ticks(ticks_to_fire());
      quiesce();
      write_reg(CSR_RUN_INTERVAL, 16'd1);
      csr_valid <= 1'b0;
      // the running countdown still uses the old interval
      send_random_ticks(ticks_to_fire());
   endtask

   task automatic test_directed_extremes();
      // full gains and limits
      program_regs(1, 1023, 65535, 65535, 65535, 32767, 65535, 255);
      send_tick(16'sh7FFF, 11'd0);
      send_tick(16'sh8000, 11'd2047);
      send_tick(16'sh0000, 11'd1079);
      send_tick(16'sh7FFF, 11'd2047);
      send_tick(16'sh8000, 11'd0);
      send_tick(16'sh0000, 11'd0);
      // zero scale, zero limits
      program_regs(1, 0, 256, 0, 65535, 0, 0, 0);
      send_tick(16'sh7FFF, 11'd1079);
      send_tick(16'sh8000, 11'd5);
      send_tick(16'sh0001, 11'd1024);
      // nominal loop, forward then backward through position zero
      program_regs(1, 62, 41, 300, 20, 100, 1500, 200);
      send_tick(16'sd1000, 11'd1070);
      send_tick(16'sd1000, 11'd1075);
      send_tick(16'sd1000, 11'd5);
      send_tick(16'sd1000, 11'd12);
      send_tick(-16'sd800, 11'd1075);
      send_tick(-16'sd800, 11'd1060);
      send_tick(-16'sd800, 11'd1040);
      send_tick(16'sd0,    11'd1040);
      send_tick(16'sd0,    11'd1040);
   endtask

   task automatic test_random_settings(input int count);
      int done, chunk, ss, sl;
      done = 0;
      while (done < count) begin
         case ($urandom_range(9))
            0:       ss = 0;
            1:       ss = 1023;
            2:       ss = int'($urandom_range(1023));
            default: ss = int'($urandom_range(1, 100));
         endcase
         sl = ($urandom_range(4) == 0) ? int'($urandom_range(65535))
                                       : ((ss * 540 > 65535) ? 65535 : ss * 540);
         program_regs(($urandom_range(19) == 0) ? int'($urandom_range(5, 40))
                                                : int'($urandom_range(1, 4)),
                      ss, pick_gain(), pick_gain(), pick_gain(),
                      ($urandom_range(5) == 0) ? 32767 * $urandom_range(1)
                                               : int'($urandom_range(32767)),
                      sl, int'($urandom_range(255)));
         chunk = (count - done < 55) ? count - done : 55;
         send_random_ticks(chunk);
         done += chunk;
      end
   endtask

   task automatic test_interval_extremes();
      quiesce();
      write_reg(CSR_RUN_INTERVAL, 16'd97);
      csr_valid <= 1'b0;
      send_random_ticks(ticks_to_fire());
      quiesce();
      write_reg(CSR_RUN_INTERVAL, 16'd1);
      csr_valid <= 1'b0;
      // a full interval of 97 ticks before the next run
      send_random_ticks(ticks_to_fire());
   endtask

   task automatic test_output_backpressure();
      program_regs(1, 62, 41, 16, 8, 24800, 1500, 200);
      hold_requests++;
      send_random_ticks(30);
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random ready, plus long holds on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_updates
      speed_update_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_updates.size() == 0) begin
            $error("unexpected item: direction %0d magnitude %0d measured_speed %0d",
                   rsp_direction, rsp_magnitude, rsp_measured_speed);
            mismatch_count++;
         end else begin
            want = expected_updates.pop_front();
            updates_checked++;
            if (rsp_direction !== want.direction) begin
               $error("direction: expected %0d, got %0d", want.direction, rsp_direction);
               mismatch_count++;
            end
            if (rsp_magnitude !== want.magnitude) begin
               $error("magnitude: expected %0d, got %0d", want.magnitude, rsp_magnitude);
               mismatch_count++;
            end
            if (rsp_measured_speed !== want.measured_speed) begin
               $error("measured_speed: expected %0d, got %0d",
                      want.measured_speed, rsp_measured_speed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d updates still pending", expected_updates.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 35;
      recv_idle_pct = 83;
      test_reset_defaults();
      test_directed_extremes();
      test_random_settings(RANDOM_TICKS);

      send_idle_pct = 83;
      recv_idle_pct = 35;
      test_random_settings(RANDOM_TICKS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings(RANDOM_TICKS);
      test_interval_extremes();
      test_output_backpressure();

      quiesce();
      if (expected_updates.size() != 0) begin
         $error("%0d expected updates never arrived", expected_updates.size());
         mismatch_count++;
      end
      $display("Run covered %0d ticks, %0d controller updates, %0d register writes.",
               ticks_sent, updates_checked, reg_writes);
      $display("Included zero and full gains, scale and limits, wrap both ways, long rsp hold.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: incremental_pid_speed_controller.f
rtl/core/ipsc_pkg.sv
rtl/core/incremental_pid_speed_controller.sv
tb/tb_incremental_pid_speed_controller.sv
